@@ src/mbrc_pkg.sv @@
// shared types, codes and constants of the modbus tcp read client framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbrc_pkg;

  localparam int MAX_FRAME_BYTES = 128;
  localparam int FRAME_BYTES     = 12;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  localparam logic [7:0] UNIT_RESET  = 8'd1;
  localparam logic [7:0] MBAP_LENGTH = 8'd6;

  // input commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_REPLY   = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // read function codes
  localparam logic [7:0] FC_COILS     = 8'd1;
  localparam logic [7:0] FC_DISCRETES = 8'd2;
  localparam logic [7:0] FC_HOLDING   = 8'd3;
  localparam logic [7:0] FC_INPUTS    = 8'd4;

  // result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_VALUE   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // transaction status
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_FUNCTION  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG      = 3'd2;
  localparam logic [2:0] ST_ID_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_CODE_MISMATCH = 3'd4;
  localparam logic [2:0] ST_TIMEOUT       = 3'd5;

  // reply byte positions
  localparam logic [7:0] POS_ID_HIGH = 8'd0;
  localparam logic [7:0] POS_ID_LOW  = 8'd1;
  localparam logic [7:0] POS_FUNC    = 8'd7;
  localparam logic [7:0] POS_COUNT   = 8'd8;
  localparam logic [7:0] POS_DATA    = 8'd9;

  // job types between front and back
  localparam logic [1:0] JOB_FRAME = 2'd0;
  localparam logic [1:0] JOB_BITS  = 2'd1;
  localparam logic [1:0] JOB_WORD  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [9:0]  item_index;
    logic [2:0]  status;
    logic [31:0] total_count;
    logic [31:0] failed_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0]                   job_type;
    logic [3:0]                   ndata;
    logic                         has_status;
    logic [2:0]                   status;
    logic [15:0]                  data;
    logic [9:0]                   base_index;
    logic [FRAME_BYTES-1:0][7:0]  frame;
    logic [31:0]                  total_count;
    logic [31:0]                  failed_count;
  } job_t;

endpackage

`default_nettype wire

@@ src/mbrc_front.sv @@
// front part: accepts items, keeps the transaction state and turns each item into at most one job
// depends on mbrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbrc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire mbrc_pkg::in_t item,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  output logic               job_valid,
  output mbrc_pkg::job_t     job
);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_WAIT = 1'b1;

  logic [7:0]  unit_address;
  logic [15:0] transaction_id, transaction_id_next;
  logic        phase, phase_next;
  logic [2:0]  active_function, active_function_next;
  logic [15:0] active_quantity, active_quantity_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  received_length, received_length_next;
  logic [7:0]  reply_id_high, reply_id_high_next;
  logic [7:0]  reply_data_count, reply_data_count_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;
  logic [9:0]  values_emitted, values_emitted_next;
  logic [31:0] started_total, started_total_next;
  logic [31:0] failed_total, failed_total_next;

  logic        is_bit, is_word, failing;
  logic [15:0] qty_m1;
  logic [13:0] len_bit;
  logic [17:0] len_word;
  logic [7:0]  pos, d;
  logic [10:0] d8;
  logic [15:0] avail;
  logic [3:0]  nbits;
  logic [2:0]  fail_status;

  always_comb begin
    transaction_id_next    = transaction_id;
    phase_next             = phase;
    active_function_next   = active_function;
    active_quantity_next   = active_quantity;
    expected_length_next   = expected_length;
    received_length_next   = received_length;
    reply_id_high_next     = reply_id_high;
    reply_data_count_next  = reply_data_count;
    pending_high_byte_next = pending_high_byte;
    values_emitted_next    = values_emitted;
    started_total_next     = started_total;
    failed_total_next      = failed_total;
    job                    = '0;
    failing                = 1'b0;
    fail_status            = mbrc_pkg::ST_OK;

    is_bit   = (item.function_code == mbrc_pkg::FC_COILS) ||
               (item.function_code == mbrc_pkg::FC_DISCRETES);
    is_word  = (item.function_code == mbrc_pkg::FC_HOLDING) ||
               (item.function_code == mbrc_pkg::FC_INPUTS);
    qty_m1   = item.quantity - 16'd1;
    len_bit  = (item.quantity == 16'd0) ? 14'd10 : 14'd10 + {1'b0, qty_m1[15:3]};
    len_word = 18'd9 + {1'b0, item.quantity, 1'b0};
    pos      = received_length;
    d        = pos - mbrc_pkg::POS_DATA;
    d8       = {d, 3'b000};
    avail    = active_quantity - {5'b0, d8};
    nbits    = (avail >= 16'd8) ? 4'd8 : avail[3:0];

    if (take) begin
      unique case (item.cmd)
        mbrc_pkg::CMD_START: begin
          if (phase == PH_IDLE) begin
            started_total_next = started_total + 32'd1;
            priority if (!is_bit && !is_word) begin
              failing     = 1'b1;
              fail_status = mbrc_pkg::ST_BAD_FUNCTION;
            end else if (is_bit ? (len_bit > 14'(mbrc_pkg::MAX_FRAME_BYTES))
                                : (len_word > 18'(mbrc_pkg::MAX_FRAME_BYTES))) begin
              failing     = 1'b1;
              fail_status = mbrc_pkg::ST_TOO_LONG;
            end else begin
              transaction_id_next    = transaction_id + 16'd1;
              phase_next             = PH_WAIT;
              active_function_next   = item.function_code[2:0];
              active_quantity_next   = item.quantity;
              expected_length_next   = is_bit ? len_bit[7:0] : len_word[7:0];
              received_length_next   = '0;
              reply_id_high_next     = '0;
              reply_data_count_next  = '0;
              pending_high_byte_next = '0;
              values_emitted_next    = '0;
              job.job_type  = mbrc_pkg::JOB_FRAME;
              job.ndata     = 4'(mbrc_pkg::FRAME_BYTES);
              job.frame[0]  = transaction_id_next[15:8];
              job.frame[1]  = transaction_id_next[7:0];
              job.frame[2]  = 8'd0;
              job.frame[3]  = 8'd0;
              job.frame[4]  = 8'd0;
              job.frame[5]  = mbrc_pkg::MBAP_LENGTH;
              job.frame[6]  = unit_address;
              job.frame[7]  = item.function_code;
              job.frame[8]  = item.start_address[15:8];
              job.frame[9]  = item.start_address[7:0];
              job.frame[10] = item.quantity[15:8];
              job.frame[11] = item.quantity[7:0];
            end
          end
        end
        mbrc_pkg::CMD_REPLY: begin
          if (phase == PH_WAIT) begin
            received_length_next = received_length + 8'd1;
            priority if (pos == mbrc_pkg::POS_ID_HIGH) begin
              reply_id_high_next = item.rx_byte;
            end else if (pos == mbrc_pkg::POS_ID_LOW) begin
              if ({reply_id_high, item.rx_byte} != transaction_id) begin
                failing     = 1'b1;
                fail_status = mbrc_pkg::ST_ID_MISMATCH;
              end
            end else if (pos == mbrc_pkg::POS_FUNC) begin
              if (item.rx_byte != {5'b0, active_function}) begin
                failing     = 1'b1;
                fail_status = mbrc_pkg::ST_CODE_MISMATCH;
              end
            end else if (pos == mbrc_pkg::POS_COUNT) begin
              reply_data_count_next = item.rx_byte;
            end else if (pos >= mbrc_pkg::POS_DATA) begin
              if (active_function >= mbrc_pkg::FC_HOLDING[2:0]) begin
                if (!d[0]) begin
                  pending_high_byte_next = item.rx_byte;
                end else if (d[7:1] < reply_data_count[7:1]) begin
                  job.job_type        = mbrc_pkg::JOB_WORD;
                  job.ndata           = 4'd1;
                  job.data            = {pending_high_byte, item.rx_byte};
                  job.base_index      = values_emitted;
                  values_emitted_next = values_emitted + 10'd1;
                end
              end else if (active_quantity > {5'b0, d8}) begin
                job.job_type        = mbrc_pkg::JOB_BITS;
                job.ndata           = nbits;
                job.data            = {8'd0, item.rx_byte};
                job.base_index      = values_emitted;
                values_emitted_next = values_emitted + {6'd0, nbits};
              end
            end else begin
              // header bytes are not checked
            end
            if (!failing && (received_length_next >= expected_length)) begin
              phase_next     = PH_IDLE;
              job.has_status = 1'b1;
              job.status     = mbrc_pkg::ST_OK;
            end
          end
        end
        mbrc_pkg::CMD_TIMEOUT: begin
          if (phase == PH_WAIT) begin
            failing     = 1'b1;
            fail_status = mbrc_pkg::ST_TIMEOUT;
          end
        end
        default: begin
        end
      endcase
    end

    if (failing) begin
      failed_total_next = failed_total + 32'd1;
      phase_next        = PH_IDLE;
      job.ndata         = 4'd0;
      job.has_status    = 1'b1;
      job.status        = fail_status;
    end

    job.total_count  = started_total_next;
    job.failed_count = failed_total_next;
    job_valid        = (job.ndata != 4'd0) || job.has_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_address      <= mbrc_pkg::UNIT_RESET;
      transaction_id    <= '0;
      phase             <= PH_IDLE;
      active_function   <= '0;
      active_quantity   <= '0;
      expected_length   <= '0;
      received_length   <= '0;
      reply_id_high     <= '0;
      reply_data_count  <= '0;
      pending_high_byte <= '0;
      values_emitted    <= '0;
      started_total     <= '0;
      failed_total      <= '0;
    end else begin
      if (cfg_we) begin
        unit_address <= cfg_data;
      end
      transaction_id    <= transaction_id_next;
      phase             <= phase_next;
      active_function   <= active_function_next;
      active_quantity   <= active_quantity_next;
      expected_length   <= expected_length_next;
      received_length   <= received_length_next;
      reply_id_high     <= reply_id_high_next;
      reply_data_count  <= reply_data_count_next;
      pending_high_byte <= pending_high_byte_next;
      values_emitted    <= values_emitted_next;
      started_total     <= started_total_next;
      failed_total      <= failed_total_next;
    end
  end

endmodule

`default_nettype wire

@@ src/mbrc_queue.sv @@
// short job queue between the front and back parts
// depends on mbrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbrc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire mbrc_pkg::job_t wr_job,
  input  wire logic           rd,
  output logic                full,
  output logic                valid,
  output mbrc_pkg::job_t      head
);

  mbrc_pkg::job_t                 slots [mbrc_pkg::QDEPTH];
  logic [mbrc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [mbrc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [mbrc_pkg::QPTR_W:0]      count;

  assign full  = (count == (mbrc_pkg::QPTR_W+1)'(mbrc_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + (mbrc_pkg::QPTR_W)'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + (mbrc_pkg::QPTR_W)'(1);
      end
      unique case ({wr, rd})
        2'b10:   count <= count + (mbrc_pkg::QPTR_W+1)'(1);
        2'b01:   count <= count - (mbrc_pkg::QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/mbrc_back.sv @@
// back part: expands each job into result transfers through an output register
// depends on mbrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbrc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire mbrc_pkg::job_t job,
  output logic                job_done,
  input  wire logic           pop,
  output logic                empty,
  output mbrc_pkg::out_t      result
);

  logic           out_valid;
  logic [3:0]     cnt;
  logic           advance;
  logic           is_status;
  logic           is_last;
  mbrc_pkg::out_t res_next;

  assign empty   = !out_valid;
  assign advance = job_valid && (!out_valid || pop);

  always_comb begin
    is_status = job.has_status && (cnt == job.ndata);
    is_last   = job.has_status ? (cnt == job.ndata) : (cnt == job.ndata - 4'd1);
    res_next              = '0;
    res_next.total_count  = job.total_count;
    res_next.failed_count = job.failed_count;
    res_next.last         = is_last;
    if (is_status) begin
      res_next.kind   = mbrc_pkg::KIND_STATUS;
      res_next.status = job.status;
    end else begin
      unique case (job.job_type)
        mbrc_pkg::JOB_FRAME: begin
          res_next.kind       = mbrc_pkg::KIND_REQUEST;
          res_next.value      = {8'd0, job.frame[cnt]};
          res_next.item_index = {6'd0, cnt};
        end
        mbrc_pkg::JOB_BITS: begin
          res_next.kind       = mbrc_pkg::KIND_VALUE;
          res_next.value      = {15'd0, job.data[{1'b0, cnt[2:0]}]};
          res_next.item_index = job.base_index + {6'd0, cnt};
        end
        mbrc_pkg::JOB_WORD: begin
          res_next.kind       = mbrc_pkg::KIND_VALUE;
          res_next.value      = job.data;
          res_next.item_index = job.base_index;
        end
        default: begin
          res_next.kind = mbrc_pkg::KIND_STATUS;
        end
      endcase
    end
    job_done = advance && is_last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        cnt       <= is_last ? 4'd0 : cnt + 4'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/modbus_tcp_read_client_framer_unit.sv @@
// top level of the modbus tcp read client framer
// depends on mbrc_pkg, mbrc_front, mbrc_queue, mbrc_back
//
// input channel: item with push/full, transfer when push && !full
//   cmd start, when idle, opens a read and yields the 12 request bytes or a failure
//   status, cmd reply takes one reply byte, cmd timeout fails the open read
// result channel: result with empty/pop, transfer when pop && !empty
//   results come out in order, last marks the final result of an input item
// config channel: cfg_valid/cfg_ready/cfg_data writes the unit address,
//   always ready, write only while no results are outstanding
// path: the front is combinational, each job is registered in the job queue and
//   each result in the output register
// throughput: the front takes one item a cycle while the four-entry job queue
//   has room; the back hands out one result a cycle while the receiver pops, so
//   a start item yields up to 12 results, a coil byte up to 9, a word byte up to 2
// reset clears the transaction state, counters, the job queue and the output
//   register, and sets the unit address to 1
// when the receiver stalls the output register holds, the job queue fills and
//   full rises; nothing is dropped
`timescale 1ns / 1ps
`default_nettype none

module modbus_tcp_read_client_framer_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire mbrc_pkg::in_t item,
  output logic               empty,
  input  wire logic          pop,
  output mbrc_pkg::out_t     result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [7:0]    cfg_data
);

  logic           take;
  logic           job_wr;
  mbrc_pkg::job_t job_in;
  logic           q_valid;
  mbrc_pkg::job_t q_head;
  logic           job_done;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  mbrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (job_wr),
    .job       (job_in)
  );

  mbrc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_wr),
    .wr_job (job_in),
    .rd     (job_done),
    .full   (full),
    .valid  (q_valid),
    .head   (q_head)
  );

  mbrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_head),
    .job_done  (job_done),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(job_wr && full))
    else $error("job written into a full queue");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.kind == mbrc_pkg::KIND_STATUS)) |-> result.last)
    else $error("status transfer not marked last");

  a_done_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_done |-> q_valid)
    else $error("job retired from an empty queue");

endmodule

`default_nettype wire

@@ tb/sv/tb_modbus_tcp_read_client_framer_unit.sv @@
// self-checking testbench for the modbus tcp read client framer: directed and random
// read requests, replies and timeouts, each result checked against an in-bench predictor
// depends on mbrc_pkg and modbus_tcp_read_client_framer_unit
`timescale 1ns / 1ps

module tb_modbus_tcp_read_client_framer_unit;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 30;
  localparam int IDLE_PCT      = 13;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;

  typedef enum int {
    REPLY_GOOD,
    REPLY_BAD_ID,
    REPLY_BAD_CODE,
    REPLY_CUT_OFF,
    REPLY_TRAILING,
    REPLY_ODD_COUNT
  } reply_mode_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           push      = 1'b0;
  logic           full;
  mbrc_pkg::in_t  item      = '0;
  logic           empty;
  logic           pop       = 1'b0;
  mbrc_pkg::out_t result;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [7:0]     cfg_data  = 8'h00;

  // framer state as predicted
  logic [15:0] txn_id         = '0;
  bit          awaiting_reply = 1'b0;
  logic [2:0]  active_fc      = '0;
  logic [15:0] active_qty     = '0;
  logic [7:0]  reply_len      = '0;
  logic [7:0]  bytes_seen     = '0;
  logic [7:0]  id_high_byte   = '0;
  logic [7:0]  data_count     = '0;
  logic [7:0]  word_high_byte = '0;
  logic [9:0]  value_index    = '0;
  logic [31:0] txn_started    = '0;
  logic [31:0] txn_failed     = '0;
  logic [7:0]  unit_addr      = mbrc_pkg::UNIT_RESET;

  mbrc_pkg::out_t awaited_results[$];

  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cfg_writes      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_req        = 0;
  int unsigned hold_left       = 0;
  bit          steady          = 1'b0;

  modbus_tcp_read_client_framer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic mbrc_pkg::out_t make_result(logic [1:0] kind, logic [15:0] value,
                                                 logic [9:0] idx, logic [2:0] st);
    mbrc_pkg::out_t r;
    r            = '0;
    r.kind       = kind;
    r.value      = value;
    r.item_index = idx;
    r.status     = st;
    return r;
  endfunction

  function automatic mbrc_pkg::in_t make_item(logic [1:0] cmd, logic [7:0] fc,
                                              logic [15:0] addr, logic [15:0] qty,
                                              logic [7:0] rx);
    mbrc_pkg::in_t it;
    it.cmd           = cmd;
    it.function_code = fc;
    it.start_address = addr;
    it.quantity      = qty;
    it.rx_byte       = rx;
    return it;
  endfunction

  // works out the results of one accepted item and queues them
  task automatic predict_framer_results(mbrc_pkg::in_t it);
    mbrc_pkg::out_t batch[$];
    logic [7:0]     frame_bytes [mbrc_pkg::FRAME_BYTES];
    int unsigned    q;
    int unsigned    frame_len;
    int unsigned    pos;
    int unsigned    d;
    int             k;
    bit             failed;
    logic [2:0]     fail_code;
    failed    = 1'b0;
    fail_code = mbrc_pkg::ST_OK;
    frame_len = 0;
    q         = it.quantity;
    case (it.cmd)
      mbrc_pkg::CMD_START: begin
        if (!awaiting_reply) begin
          txn_started++;
          if (it.function_code == mbrc_pkg::FC_COILS ||
              it.function_code == mbrc_pkg::FC_DISCRETES) begin
            frame_len = (q == 0) ? 10 : 10 + (q - 1) / 8;
          end else if (it.function_code == mbrc_pkg::FC_HOLDING ||
                       it.function_code == mbrc_pkg::FC_INPUTS) begin
            frame_len = 9 + 2 * q;
          end else begin
            failed    = 1'b1;
            fail_code = mbrc_pkg::ST_BAD_FUNCTION;
          end
          if (!failed && frame_len > mbrc_pkg::MAX_FRAME_BYTES) begin
            failed    = 1'b1;
            fail_code = mbrc_pkg::ST_TOO_LONG;
          end
          if (!failed) begin
            txn_id++;
            awaiting_reply  = 1'b1;
            active_fc       = it.function_code[2:0];
            active_qty      = it.quantity;
            reply_len       = 8'(frame_len);
            bytes_seen      = '0;
            id_high_byte    = '0;
            data_count      = '0;
            word_high_byte  = '0;
            value_index     = '0;
            frame_bytes[0]  = txn_id[15:8];
            frame_bytes[1]  = txn_id[7:0];
            frame_bytes[2]  = 8'h00;
            frame_bytes[3]  = 8'h00;
            frame_bytes[4]  = 8'h00;
            frame_bytes[5]  = mbrc_pkg::MBAP_LENGTH;
            frame_bytes[6]  = unit_addr;
            frame_bytes[7]  = it.function_code;
            frame_bytes[8]  = it.start_address[15:8];
            frame_bytes[9]  = it.start_address[7:0];
            frame_bytes[10] = it.quantity[15:8];
            frame_bytes[11] = it.quantity[7:0];
            for (k = 0; k < mbrc_pkg::FRAME_BYTES; k++)
              batch.push_back(make_result(mbrc_pkg::KIND_REQUEST, {8'h00, frame_bytes[k]},
                                          10'(k), mbrc_pkg::ST_OK));
          end
        end
      end
      mbrc_pkg::CMD_REPLY: begin
        if (awaiting_reply) begin
          pos = bytes_seen;
          bytes_seen++;
          if (pos == mbrc_pkg::POS_ID_HIGH) begin
            id_high_byte = it.rx_byte;
          end else if (pos == mbrc_pkg::POS_ID_LOW) begin
            if ({id_high_byte, it.rx_byte} != txn_id) begin
              failed    = 1'b1;
              fail_code = mbrc_pkg::ST_ID_MISMATCH;
            end
          end else if (pos == mbrc_pkg::POS_FUNC) begin
            if (it.rx_byte != {5'd0, active_fc}) begin
              failed    = 1'b1;
              fail_code = mbrc_pkg::ST_CODE_MISMATCH;
            end
          end else if (pos == mbrc_pkg::POS_COUNT) begin
            data_count = it.rx_byte;
          end else if (pos >= mbrc_pkg::POS_DATA) begin
            d = pos - mbrc_pkg::POS_DATA;
            if (active_fc >= mbrc_pkg::FC_HOLDING[2:0]) begin
              if (d % 2 == 0) begin
                word_high_byte = it.rx_byte;
              end else if (d / 2 < data_count / 2) begin
                batch.push_back(make_result(mbrc_pkg::KIND_VALUE,
                                            {word_high_byte, it.rx_byte},
                                            value_index, mbrc_pkg::ST_OK));
                value_index++;
              end
            end else begin
              for (k = 0; k < 8; k++) begin
                if (d * 8 + k < active_qty) begin
                  batch.push_back(make_result(mbrc_pkg::KIND_VALUE, {15'd0, it.rx_byte[k]},
                                              value_index, mbrc_pkg::ST_OK));
                  value_index++;
                end
              end
            end
          end
          if (!failed && bytes_seen >= reply_len) begin
            awaiting_reply = 1'b0;
            batch.push_back(make_result(mbrc_pkg::KIND_STATUS, '0, '0, mbrc_pkg::ST_OK));
          end
        end
      end
      mbrc_pkg::CMD_TIMEOUT: begin
        if (awaiting_reply) begin
          failed    = 1'b1;
          fail_code = mbrc_pkg::ST_TIMEOUT;
        end
      end
      default: ;
    endcase
    if (failed) begin
      txn_failed++;
      awaiting_reply = 1'b0;
      batch.push_back(make_result(mbrc_pkg::KIND_STATUS, '0, '0, fail_code));
    end
    foreach (batch[i]) begin
      batch[i].total_count  = txn_started;
      batch[i].failed_count = txn_failed;
      batch[i].last         = (i == batch.size() - 1);
      awaited_results.push_back(batch[i]);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result(mbrc_pkg::out_t got);
    mbrc_pkg::out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: kind %0d value 0x%0h",
                                got.kind, got.value));
    end else begin
      want = awaited_results.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("value", got.value, want.value);
      check_field("item_index", got.item_index, want.item_index);
      check_field("status", got.status, want.status);
      check_field("total_count", got.total_count, want.total_count);
      check_field("failed_count", got.failed_count, want.failed_count);
      check_field("last", got.last, want.last);
    end
    results_checked++;
  endtask

  // result side: check each transfer, random stalls and requested hold-offs
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        check_result(result);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0)
        hold_left--;
      pop <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, awaited_results.size());
      $display("[modbus_tcp_read_client_framer_unit] ERROR");
      $finish;
    end
  end

  task automatic send_item(mbrc_pkg::in_t it);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
    predict_framer_results(it);
  endtask

  task automatic drain_results;
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit_address(logic [7:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unit_addr = v;
    cfg_writes++;
  endtask

  task automatic send_reply_byte(logic [7:0] b);
    send_item(make_item(mbrc_pkg::CMD_REPLY, 8'($urandom), 16'($urandom),
                        16'($urandom), b));
  endtask

  task automatic send_timeout;
    send_item(make_item(mbrc_pkg::CMD_TIMEOUT, 8'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom)));
  endtask

  task automatic start_read(logic [7:0] fc, logic [15:0] addr, logic [15:0] qty);
    send_item(make_item(mbrc_pkg::CMD_START, fc, addr, qty, 8'($urandom)));
  endtask

  // answers the open read with a reply shaped by mode
  task automatic answer_read(reply_mode_t mode);
    logic [15:0] id;
    logic [2:0]  fc;
    logic [15:0] qty;
    logic [7:0]  unit_b;
    logic [7:0]  count;
    logic [7:0]  b;
    int unsigned len;
    int unsigned n_send;
    int unsigned bad_pos;
    int          k;
    bit          noisy_header;
    if (awaiting_reply) begin
      id     = txn_id;
      fc     = active_fc;
      qty    = active_qty;
      len    = reply_len;
      unit_b = unit_addr;
      if (fc >= mbrc_pkg::FC_HOLDING[2:0])
        count = 8'(32'(qty) * 2);
      else
        count = 8'((32'(qty) + 7) / 8);
      if (mode == REPLY_ODD_COUNT)
        count = 8'($urandom);
      n_send = (mode == REPLY_CUT_OFF) ? $urandom_range(0, len - 1) : len;
      bad_pos = (mode == REPLY_BAD_ID) ? $urandom_range(0, 1) : mbrc_pkg::POS_FUNC;
      noisy_header = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n_send; k++) begin
        case (k)
          0: b = id[15:8];
          1: b = id[7:0];
          2, 3, 4: b = 8'h00;
          5: b = 8'(len - 6);
          6: b = unit_b;
          7: b = {5'd0, fc};
          8: b = count;
          default: b = 8'($urandom);
        endcase
        if (noisy_header && k >= 2 && k <= 6)
          b = 8'($urandom);
        if ((mode == REPLY_BAD_ID || mode == REPLY_BAD_CODE) && k == bad_pos)
          b = b ^ 8'($urandom_range(1, 255));
        send_reply_byte(b);
      end
      if (mode == REPLY_CUT_OFF)
        send_timeout();
      if (mode == REPLY_TRAILING) begin
        repeat ($urandom_range(1, 3)) send_reply_byte(8'($urandom));
        send_timeout();
      end
    end
  endtask

  task automatic read_transaction(logic [7:0] fc, logic [15:0] qty, reply_mode_t mode);
    start_read(fc, 16'($urandom), qty);
    answer_read(mode);
  endtask

  task automatic test_idle_commands;
    send_reply_byte(8'hFF);
    send_timeout();
    send_item(make_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(make_item(CMD_UNUSED, 8'h00, 16'h0000, 16'h0000, 8'h00));
  endtask

  task automatic test_request_errors;
    start_read(8'h00, 16'h0000, 16'h0000);
    start_read(8'h05, 16'hFFFF, 16'h0001);
    start_read(8'hFF, 16'hFFFF, 16'hFFFF);
    start_read(mbrc_pkg::FC_HOLDING, 16'h1234, 16'd60);
    start_read(mbrc_pkg::FC_INPUTS, 16'hFFFF, 16'hFFFF);
    start_read(mbrc_pkg::FC_COILS, 16'h0000, 16'd953);
    start_read(mbrc_pkg::FC_DISCRETES, 16'h8000, 16'hFFFF);
    // bit read whose reply just fits the frame limit, then given up
    start_read(mbrc_pkg::FC_COILS, 16'hFFFF, 16'd945);
    send_timeout();
  endtask

  task automatic test_start_while_busy;
    start_read(mbrc_pkg::FC_INPUTS, 16'h0000, 16'd1);
    start_read(mbrc_pkg::FC_HOLDING, 16'hFFFF, 16'd2);
    send_timeout();
  endtask

  task automatic test_reply_decoding;
    read_transaction(mbrc_pkg::FC_COILS, 16'd0, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_DISCRETES, 16'd9, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_HOLDING, 16'd0, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_INPUTS, 16'd2, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_HOLDING, 16'd3, REPLY_BAD_ID);
    read_transaction(mbrc_pkg::FC_COILS, 16'd5, REPLY_BAD_CODE);
    read_transaction(mbrc_pkg::FC_INPUTS, 16'd4, REPLY_ODD_COUNT);
  endtask

  task automatic test_unit_address;
    write_unit_address(8'h00);
    read_transaction(mbrc_pkg::FC_INPUTS, 16'd1, REPLY_GOOD);
    write_unit_address(8'hFF);
    read_transaction(mbrc_pkg::FC_COILS, 16'd3, REPLY_GOOD);
    write_unit_address(8'($urandom));
    read_transaction(mbrc_pkg::FC_HOLDING, 16'd1, REPLY_TRAILING);
  endtask

  task automatic test_backpressure;
    drain_results();
    hold_req = HOLD_CYCLES;
    read_transaction(mbrc_pkg::FC_HOLDING, 16'd6, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_COILS, 16'd24, REPLY_GOOD);
    drain_results();
  endtask

  task automatic test_steady_stream;
    steady = 1'b1;
    read_transaction(mbrc_pkg::FC_DISCRETES, 16'd17, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_INPUTS, 16'd2, REPLY_GOOD);
    read_transaction(mbrc_pkg::FC_COILS, 16'd3, REPLY_TRAILING);
    drain_results();
    steady = 1'b0;
  endtask

  task automatic random_step;
    int          pick;
    logic [7:0]  fc;
    logic [15:0] qty;
    reply_mode_t mode;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_item(make_item(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom)));
      if (awaiting_reply && $urandom_range(0, 1) == 0)
        send_timeout();
    end else begin
      fc = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 19) == 0)
        fc = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (fc == mbrc_pkg::FC_HOLDING || fc == mbrc_pkg::FC_INPUTS)
        qty = (pick < 85) ? 16'($urandom_range(0, 8)) :
              (pick < 95) ? 16'($urandom_range(0, 59)) : 16'($urandom);
      else
        qty = (pick < 85) ? 16'($urandom_range(0, 40)) :
              (pick < 95) ? 16'($urandom_range(0, 300)) : 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55)      mode = REPLY_GOOD;
      else if (pick < 63) mode = REPLY_BAD_ID;
      else if (pick < 71) mode = REPLY_BAD_CODE;
      else if (pick < 81) mode = REPLY_CUT_OFF;
      else if (pick < 91) mode = REPLY_TRAILING;
      else                mode = REPLY_ODD_COUNT;
      read_transaction(fc, qty, mode);
    end
  endtask

  task automatic test_random_traffic;
    int unsigned goal;
    int          phase_n;
    for (phase_n = 0; phase_n < 3; phase_n++) begin
      goal = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < goal)
        random_step();
      if (phase_n < 2)
        write_unit_address(8'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_commands();
    test_request_errors();
    test_start_while_busy();
    test_reply_decoding();
    test_unit_address();
    test_backpressure();
    test_steady_stream();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d input items and %0d results: %0d reads started, %0d failed",
             items_sent, results_checked, txn_started, txn_failed);
    $display("with %0d unit address writes, a %0d-cycle result hold-off and a no-stall stretch",
             cfg_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[modbus_tcp_read_client_framer_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[modbus_tcp_read_client_framer_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mbrc_pkg.sv
src/mbrc_front.sv
src/mbrc_queue.sv
src/mbrc_back.sv
src/modbus_tcp_read_client_framer_unit.sv
tb/sv/tb_modbus_tcp_read_client_framer_unit.sv
